@@ rtl/cps_pkg.sv @@
// shared types and constants for the cpu process scheduler
// no dependencies; imported by every module of the block
package cps_pkg;

  localparam int unsigned Slots      = 16;
  localparam int unsigned SlotW      = $clog2(Slots);
  localparam int unsigned TimeW      = 24;
  localparam int unsigned QuantW     = 16;
  localparam int unsigned PolicyW    = 2;
  localparam int unsigned CfgIdxW    = 1;
  localparam logic [QuantW-1:0] QuantReset = QuantW'(500);

  // scheduling policies
  typedef enum logic [PolicyW-1:0] {
    POL_FIFO = 2'd0,
    POL_RR   = 2'd1,
    POL_SJF  = 2'd2,
    POL_PSJF = 2'd3
  } policy_e;

  // host commands
  localparam logic CmdArrive = 1'b0;
  localparam logic CmdTick   = 1'b1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgPolicy  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgQuantum = 1'b1;

  // write request into the job table
  typedef struct packed {
    logic             we;
    logic [SlotW-1:0] addr;
    logic [TimeW-1:0] data;
    logic             set_pres;
    logic             clr_pres;
  } tbl_wr_t;

  // one scanned entry, lined up with the table read data
  typedef struct packed {
    logic             vld;
    logic             elig;
    logic [SlotW-1:0] slot;
  } scan_smp_t;

  // per-tick control of the compare unit
  typedef struct packed {
    logic             clear;
    logic             by_time;
    logic             cur_ok;
    logic [SlotW-1:0] cur_slot;
  } scan_ctl_t;

  // current pick of the compare unit
  typedef struct packed {
    logic             have;
    logic [SlotW-1:0] slot;
    logic [TimeW-1:0] rem;
  } scan_res_t;

endpackage

@@ rtl/cpu_process_scheduler.sv @@
// Single-CPU job scheduler over 16 job slots with FIFO, round-robin, SJF and
// preemptive SJF policies. An arrive command goes from idle straight to the
// finishing state, which registers its result. A tick makes the sequencer walk
// all 16 slots through the single read port of the remaining-time memory and
// one shared comparator, then the finishing state updates the table and
// registers the result. The next command can be taken in the cycle after that.
// A new command is taken only while the sequencer is idle; a finished result
// may still wait in the output register then. A result that is not yet taken
// holds the sequencer in its last cycle.
// top level; depends on cps_pkg, cps_job_table and cps_scan_unit
module cpu_process_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [cps_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [cps_pkg::QuantW-1:0]    cfg_data_i,
  // commands
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          command_i,
  input  logic [cps_pkg::SlotW-1:0]     slot_i,
  input  logic [cps_pkg::TimeW-1:0]     run_length_i,
  // results
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          running_valid_o,
  output logic [cps_pkg::SlotW-1:0]     running_slot_o,
  output logic                          switched_o,
  output logic                          finished_o,
  output logic [cps_pkg::TimeW-1:0]     remaining_after_o,
  output logic                          all_idle_o
);
  import cps_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FINISH
  } state_e;

  state_e            state_q, state_d;
  logic              cmd_q, cmd_d;
  logic [SlotW-1:0]  slot_q, slot_d;
  logic [TimeW-1:0]  len_q, len_d;
  logic [SlotW:0]    cnt_q, cnt_d;
  logic              direct_q, direct_d;
  logic              reload_q, reload_d;
  logic              cur_ok_q, cur_ok_d;
  logic [SlotW-1:0]  base_q, base_d;
  logic [SlotW:0]    fifo_start_q, fifo_start_d;
  logic              by_time_q, by_time_d;
  scan_smp_t         smp_q, smp_d;

  policy_e           policy_q, policy_d;
  logic [QuantW-1:0] quantum_q, quantum_d;
  logic [QuantW-1:0] qleft_q, qleft_d;
  logic [SlotW-1:0]  last_slot_q, last_slot_d;
  logic              last_valid_q, last_valid_d;

  logic              out_valid_q, out_valid_d;
  logic              run_vld_q, run_vld_d;
  logic [SlotW-1:0]  run_slot_q, run_slot_d;
  logic              sw_q, sw_d;
  logic              fin_q, fin_d;
  logic [TimeW-1:0]  rem_after_q, rem_after_d;
  logic              idle_q, idle_d;

  logic              in_xfer, cfg_xfer, out_free, fire;
  logic              cur_ok;
  logic [SlotW-1:0]  rd_addr;
  logic [TimeW-1:0]  rd_data;
  logic [Slots-1:0]  present;
  logic [Slots-1:0]  clr_mask;
  logic [TimeW-1:0]  new_rem;
  logic [QuantW-1:0] qbase;
  tbl_wr_t           tbl_wr;
  scan_ctl_t         scan_ctl;
  scan_res_t         scan_res;

  assign cfg_ready_o = 1'b1;
  assign cfg_xfer    = cfg_valid_i && cfg_ready_o;
  assign in_ready_o  = (state_q == ST_IDLE);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_free    = !out_valid_q || out_ready_i;
  assign fire        = (state_q == ST_FINISH) && out_free;

  // the running job still holds its slot
  assign cur_ok = last_valid_q && present[last_slot_q];

  // scan address walks from the rotation base
  assign rd_addr = base_q + cnt_q[SlotW-1:0];

  // table update on the finishing cycle
  assign new_rem  = (scan_res.rem != '0) ? scan_res.rem - TimeW'(1) : '0;
  assign clr_mask = (scan_res.have && (new_rem == '0)) ?
                    (Slots'(1) << scan_res.slot) : '0;
  assign qbase    = reload_q ? quantum_q : qleft_q;

  always_comb begin
    tbl_wr = '0;
    if (fire) begin
      if (cmd_q == CmdArrive) begin
        tbl_wr.we       = 1'b1;
        tbl_wr.addr     = slot_q;
        tbl_wr.data     = len_q;
        tbl_wr.set_pres = 1'b1;
      end else if (scan_res.have) begin
        tbl_wr.we       = 1'b1;
        tbl_wr.addr     = scan_res.slot;
        tbl_wr.data     = new_rem;
        tbl_wr.clr_pres = (new_rem == '0);
      end
    end
  end

  assign scan_ctl.clear    = in_xfer;
  assign scan_ctl.by_time  = by_time_q;
  assign scan_ctl.cur_ok   = cur_ok_q;
  assign scan_ctl.cur_slot = last_slot_q;

  cps_job_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data),
    .wr_i      (tbl_wr),
    .present_o (present)
  );

  cps_scan_unit u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (scan_ctl),
    .smp_i  (smp_q),
    .rem_i  (rd_data),
    .res_o  (scan_res)
  );

  // sequencer, policy setup and result register
  always_comb begin
    state_d      = state_q;
    cmd_d        = cmd_q;
    slot_d       = slot_q;
    len_d        = len_q;
    cnt_d        = cnt_q;
    direct_d     = direct_q;
    reload_d     = reload_q;
    cur_ok_d     = cur_ok_q;
    base_d       = base_q;
    fifo_start_d = fifo_start_q;
    by_time_d    = by_time_q;
    smp_d        = '0;
    policy_d     = policy_q;
    quantum_d    = quantum_q;
    qleft_d      = qleft_q;
    last_slot_d  = last_slot_q;
    last_valid_d = last_valid_q;
    out_valid_d  = out_valid_q;
    run_vld_d    = run_vld_q;
    run_slot_d   = run_slot_q;
    sw_d         = sw_q;
    fin_d        = fin_q;
    rem_after_d  = rem_after_q;
    idle_d       = idle_q;

    // configuration writes
    if (cfg_xfer) begin
      case (cfg_index_i)
        CfgPolicy:  policy_d  = policy_e'(cfg_data_i[PolicyW-1:0]);
        CfgQuantum: quantum_d = cfg_data_i;
        default: ;
      endcase
    end

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          cmd_d        = command_i;
          slot_d       = slot_i;
          len_d        = run_length_i;
          cnt_d        = '0;
          cur_ok_d     = cur_ok;
          by_time_d    = policy_q[1];
          fifo_start_d = last_valid_q ? {1'b0, last_slot_q} + (SlotW+1)'(1) : '0;
          base_d       = '0;
          reload_d     = 1'b0;
          case (policy_q)
            POL_FIFO: direct_d = cur_ok;
            POL_RR: begin
              direct_d = cur_ok && (qleft_q != '0);
              reload_d = !(cur_ok && (qleft_q != '0));
              base_d   = cur_ok ? last_slot_q + SlotW'(1) : '0;
            end
            POL_SJF:  direct_d = cur_ok;
            POL_PSJF: direct_d = 1'b0;
            default:  direct_d = 1'b0;
          endcase
          state_d = (command_i == CmdArrive) ? ST_FINISH : ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (!cnt_q[SlotW]) begin
          smp_d.vld  = 1'b1;
          smp_d.slot = rd_addr;
          if (direct_q) begin
            smp_d.elig = present[rd_addr] && (rd_addr == last_slot_q);
          end else if (policy_q == POL_FIFO) begin
            smp_d.elig = present[rd_addr] && ({1'b0, rd_addr} >= fifo_start_q);
          end else begin
            smp_d.elig = present[rd_addr];
          end
          cnt_d = cnt_q + (SlotW+1)'(1);
        end else begin
          state_d = ST_FINISH;
        end
      end

      ST_FINISH: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          run_vld_d   = 1'b0;
          run_slot_d  = '0;
          sw_d        = 1'b0;
          fin_d       = 1'b0;
          rem_after_d = '0;
          if (cmd_q == CmdArrive) begin
            idle_d = 1'b0;
          end else begin
            qleft_d = qbase;
            if (scan_res.have) begin
              run_vld_d    = 1'b1;
              run_slot_d   = scan_res.slot;
              sw_d         = !last_valid_q || (last_slot_q != scan_res.slot);
              fin_d        = (new_rem == '0);
              rem_after_d  = new_rem;
              last_slot_d  = scan_res.slot;
              last_valid_d = 1'b1;
              if (qbase != '0) begin
                qleft_d = qbase - QuantW'(1);
              end
            end else begin
              last_valid_d = 1'b0;
            end
            idle_d = ((present & ~clr_mask) == '0);
          end
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      cmd_q        <= CmdArrive;
      slot_q       <= '0;
      len_q        <= '0;
      cnt_q        <= '0;
      direct_q     <= 1'b0;
      reload_q     <= 1'b0;
      cur_ok_q     <= 1'b0;
      base_q       <= '0;
      fifo_start_q <= '0;
      by_time_q    <= 1'b0;
      smp_q        <= '0;
      policy_q     <= POL_FIFO;
      quantum_q    <= QuantReset;
      qleft_q      <= QuantReset;
      last_slot_q  <= '0;
      last_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      run_vld_q    <= 1'b0;
      run_slot_q   <= '0;
      sw_q         <= 1'b0;
      fin_q        <= 1'b0;
      rem_after_q  <= '0;
      idle_q       <= 1'b1;
    end else begin
      state_q      <= state_d;
      cmd_q        <= cmd_d;
      slot_q       <= slot_d;
      len_q        <= len_d;
      cnt_q        <= cnt_d;
      direct_q     <= direct_d;
      reload_q     <= reload_d;
      cur_ok_q     <= cur_ok_d;
      base_q       <= base_d;
      fifo_start_q <= fifo_start_d;
      by_time_q    <= by_time_d;
      smp_q        <= smp_d;
      policy_q     <= policy_d;
      quantum_q    <= quantum_d;
      qleft_q      <= qleft_d;
      last_slot_q  <= last_slot_d;
      last_valid_q <= last_valid_d;
      out_valid_q  <= out_valid_d;
      run_vld_q    <= run_vld_d;
      run_slot_q   <= run_slot_d;
      sw_q         <= sw_d;
      fin_q        <= fin_d;
      rem_after_q  <= rem_after_d;
      idle_q       <= idle_d;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign running_valid_o   = run_vld_q;
  assign running_slot_o    = run_slot_q;
  assign switched_o        = sw_q;
  assign finished_o        = fin_q;
  assign remaining_after_o = rem_after_q;
  assign all_idle_o        = idle_q;

endmodule

@@ rtl/cps_job_table.sv @@
// job table: remaining-time memory with one registered read port and
// presence flags per slot; depends on cps_pkg
module cps_job_table (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [cps_pkg::SlotW-1:0]     rd_addr_i,
  output logic [cps_pkg::TimeW-1:0]     rd_data_o,
  input  cps_pkg::tbl_wr_t              wr_i,
  output logic [cps_pkg::Slots-1:0]     present_o
);
  import cps_pkg::*;

  logic [TimeW-1:0] mem [Slots];
  logic [TimeW-1:0] rd_data_q;
  logic [Slots-1:0] present_q, present_d;

  // remaining-time memory
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  // presence flags
  always_comb begin
    present_d = present_q;
    if (wr_i.set_pres) begin
      present_d[wr_i.addr] = 1'b1;
    end
    if (wr_i.clr_pres) begin
      present_d[wr_i.addr] = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else begin
      present_q <= present_d;
    end
  end

  assign rd_data_o = rd_data_q;
  assign present_o = present_q;

endmodule

@@ rtl/cps_scan_unit.sv @@
// shared compare unit: keeps the best candidate seen while the slots are
// scanned one per cycle; depends on cps_pkg
module cps_scan_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  cps_pkg::scan_ctl_t        ctl_i,
  input  cps_pkg::scan_smp_t        smp_i,
  input  logic [cps_pkg::TimeW-1:0] rem_i,
  output cps_pkg::scan_res_t        res_o
);
  import cps_pkg::*;

  scan_res_t res_q, res_d;
  logic      lt, eq, tie_cur, take;

  // one comparator against the current best
  assign lt      = rem_i < res_q.rem;
  assign eq      = rem_i == res_q.rem;
  assign tie_cur = eq && ctl_i.cur_ok && (smp_i.slot == ctl_i.cur_slot);
  assign take    = smp_i.vld && smp_i.elig &&
                   (!res_q.have || (ctl_i.by_time && (lt || tie_cur)));

  always_comb begin
    res_d = res_q;
    if (ctl_i.clear) begin
      res_d.have = 1'b0;
    end else if (take) begin
      res_d.have = 1'b1;
      res_d.slot = smp_i.slot;
      res_d.rem  = rem_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q.have <= 1'b0;
      res_q.slot <= '0;
      res_q.rem  <= '0;
    end else begin
      res_q <= res_d;
    end
  end

  assign res_o = res_q;

endmodule

@@ tb/sv/cps_checker.sv @@
`timescale 1ns / 1ps
// scoreboard for the cpu process scheduler: watches the config, command and result channels
// keeps its own copy of the job table and compares every result; depends on cps_pkg
module cps_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_valid_i,
  input  logic                         cfg_ready_i,
  input  logic [cps_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [cps_pkg::QuantW-1:0]   cfg_data_i,
  input  logic                         in_valid_i,
  input  logic                         in_ready_i,
  input  logic                         command_i,
  input  logic [cps_pkg::SlotW-1:0]    slot_i,
  input  logic [cps_pkg::TimeW-1:0]    run_length_i,
  input  logic                         out_valid_i,
  input  logic                         out_ready_i,
  input  logic                         running_valid_i,
  input  logic [cps_pkg::SlotW-1:0]    running_slot_i,
  input  logic                         switched_i,
  input  logic                         finished_i,
  input  logic [cps_pkg::TimeW-1:0]    remaining_after_i,
  input  logic                         all_idle_i,
  output int unsigned                  fail_count_o,
  output int unsigned                  outstanding_o
);
  import cps_pkg::*;

  typedef struct packed {
    logic             running_valid;
    logic [SlotW-1:0] running_slot;
    logic             switched;
    logic             finished;
    logic [TimeW-1:0] remaining_after;
    logic             all_idle;
  } sched_res_t;

  // shadow of the scheduler state and its registers
  policy_e           pol;
  logic [QuantW-1:0] quantum;
  logic [QuantW-1:0] quant_left;
  logic [Slots-1:0]  job_live;
  logic [TimeW-1:0]  job_left [Slots];
  logic [SlotW-1:0]  last_slot;
  logic              last_vld;

  sched_res_t  pending_results [$];
  int unsigned mismatches;

  task automatic check_field(input string field, input logic [TimeW-1:0] want,
                             input logic [TimeW-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, field, want, got);
      mismatches++;
    end
  endtask

  // one command against the shadow table: arrive loads a slot, tick runs one job
  task automatic schedule_step(input logic cmd, input logic [SlotW-1:0] slot,
                               input logic [TimeW-1:0] len, output sched_res_t res);
    logic             cur_ok;
    logic             found;
    logic [SlotW-1:0] pick;
    logic [SlotW-1:0] k;
    logic [TimeW-1:0] rem;
    int               start;
    res = '0;
    if (cmd == CmdArrive) begin
      job_live[slot] = 1'b1;
      job_left[slot] = len;
    end else begin
      cur_ok = last_vld && job_live[last_slot];
      found  = cur_ok;
      pick   = last_slot;
      case (pol)
        // keep the current job, else the next present slot above it
        POL_FIFO: begin
          if (!cur_ok) begin
            found = 1'b0;
            start = last_vld ? int'(last_slot) + 1 : 0;
            for (int i = start; i < Slots; i++) begin
              if (job_live[i] && !found) begin
                pick  = SlotW'(i);
                found = 1'b1;
              end
            end
          end
        end
        // rotate once the quantum is used up, wrapping around the table
        POL_RR: begin
          if (!cur_ok || quant_left == '0) begin
            found = 1'b0;
            start = cur_ok ? int'(last_slot) + 1 : 0;
            for (int i = 0; i < Slots; i++) begin
              k = SlotW'((start + i) % Slots);
              if (job_live[k] && !found) begin
                pick  = k;
                found = 1'b1;
              end
            end
            quant_left = quantum;
          end
        end
        // shortest remaining time, SJF keeps a live current job; ties stay with it, then the lowest slot
        POL_SJF, POL_PSJF: begin
          if (!(cur_ok && pol == POL_SJF)) begin
            for (int i = 0; i < Slots; i++) begin
              if (job_live[i] && (!found || job_left[i] < job_left[pick])) begin
                pick  = SlotW'(i);
                found = 1'b1;
              end
            end
          end
        end
        default: ;
      endcase
      if (found) begin
        rem = job_left[pick];
        res.switched = !last_vld || last_slot != pick;
        rem = (rem > 0) ? rem - 1'b1 : '0;
        job_left[pick] = rem;
        if (rem == '0) job_live[pick] = 1'b0;
        if (quant_left > 0) quant_left = quant_left - 1'b1;
        res.running_valid   = 1'b1;
        res.running_slot    = pick;
        res.finished        = (rem == '0);
        res.remaining_after = rem;
        last_slot = pick;
        last_vld  = 1'b1;
      end else begin
        last_vld = 1'b0;
      end
    end
    res.all_idle = (job_live == '0);
  endtask

  // per-edge monitor: config writes, result compare, then new expectations
  always @(posedge clk_i or negedge rst_ni) begin : monitor
    sched_res_t want;
    sched_res_t fresh;
    if (!rst_ni) begin
      pol        = POL_FIFO;
      quantum    = QuantReset;
      quant_left = QuantReset;
      job_live   = '0;
      for (int i = 0; i < Slots; i++) job_left[i] = '0;
      last_slot  = '0;
      last_vld   = 1'b0;
      pending_results.delete();
      mismatches = 0;
      fail_count_o  <= 0;
      outstanding_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CfgPolicy:  pol     = policy_e'(cfg_data_i[PolicyW-1:0]);
          CfgQuantum: quantum = cfg_data_i;
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with nothing expected, slot %0d remaining %0d",
                   $time, running_slot_i, remaining_after_i);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("running_valid", TimeW'(want.running_valid),
                      TimeW'(running_valid_i));
          check_field("running_slot", TimeW'(want.running_slot),
                      TimeW'(running_slot_i));
          check_field("switched", TimeW'(want.switched), TimeW'(switched_i));
          check_field("finished", TimeW'(want.finished), TimeW'(finished_i));
          check_field("remaining_after", want.remaining_after, remaining_after_i);
          check_field("all_idle", TimeW'(want.all_idle), TimeW'(all_idle_i));
        end
      end
      if (in_valid_i && in_ready_i) begin
        schedule_step(command_i, slot_i, run_length_i, fresh);
        pending_results.push_back(fresh);
      end
      fail_count_o  <= mismatches;
      outstanding_o <= pending_results.size();
    end
  end

endmodule

@@ tb/sv/tb_cpu_process_scheduler.sv @@
`timescale 1ns / 1ps
// top of the cpu process scheduler testbench: clock, reset, stimulus and verdict
// depends on cps_pkg, cpu_process_scheduler and cps_checker
module tb_cpu_process_scheduler;
  import cps_pkg::*;

  logic                clk        = 1'b0;
  logic                rst_n      = 1'b0;
  logic                cfg_valid  = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index  = CfgPolicy;
  logic [QuantW-1:0]   cfg_data   = '0;
  logic                in_valid   = 1'b0;
  logic                in_ready;
  logic                command    = CmdArrive;
  logic [SlotW-1:0]    slot       = '0;
  logic [TimeW-1:0]    run_length = '0;
  logic                out_valid;
  logic                out_ready  = 1'b0;
  logic                running_valid;
  logic [SlotW-1:0]    running_slot;
  logic                switched;
  logic                finished;
  logic [TimeW-1:0]    remaining_after;
  logic                all_idle;
  int unsigned         fail_count;
  int unsigned         outstanding;

  logic                hold_req   = 1'b0;
  logic                hold_done  = 1'b0;
  int unsigned         quiet_items = 0;

  // policy and quantum for each random phase, extremes included
  policy_e           phase_pol   [8] = '{POL_RR, POL_RR, POL_SJF, POL_PSJF,
                                         POL_RR, POL_FIFO, POL_PSJF, POL_RR};
  logic [QuantW-1:0] phase_quant [8] = '{16'd2, 16'd0, 16'd65535, 16'd1,
                                         16'd65535, 16'd7, 16'd500, 16'd1};

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  cpu_process_scheduler DUT (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_o        (in_ready),
    .command_i         (command),
    .slot_i            (slot),
    .run_length_i      (run_length),
    .out_valid_o       (out_valid),
    .out_ready_i       (out_ready),
    .running_valid_o   (running_valid),
    .running_slot_o    (running_slot),
    .switched_o        (switched),
    .finished_o        (finished),
    .remaining_after_o (remaining_after),
    .all_idle_o        (all_idle)
  );

  cps_checker u_checker (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .in_valid_i        (in_valid),
    .in_ready_i        (in_ready),
    .command_i         (command),
    .slot_i            (slot),
    .run_length_i      (run_length),
    .out_valid_i       (out_valid),
    .out_ready_i       (out_ready),
    .running_valid_i   (running_valid),
    .running_slot_i    (running_slot),
    .switched_i        (switched),
    .finished_i        (finished),
    .remaining_after_i (remaining_after),
    .all_idle_i        (all_idle),
    .fail_count_o      (fail_count),
    .outstanding_o     (outstanding)
  );

  // one command transfer, after a random gap; valid stays up for back-to-back items
  task automatic send_cmd(input logic cmd, input logic [SlotW-1:0] s,
                          input logic [TimeW-1:0] len);
    int unsigned gap;
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet_items > 0) begin
      quiet_items--;
      gap = 0;
    end else if (r < 4) begin
      quiet_items = $urandom_range(10, 30);
      gap = 0;
    end else if (r < 55) begin
      gap = 0;
    end else if (r < 90) begin
      gap = $urandom_range(1, 4);
    end else begin
      gap = $urandom_range(10, 60);
    end
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    command    <= cmd;
    slot       <= s;
    run_length <= len;
    do @(posedge clk); while (!in_ready);
  endtask

  // register write transfer; the caller drops valid after the last one
  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [QuantW-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // stop sending and wait until every expected result has come back
  task automatic drain(input int unsigned tail);
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (tail) @(posedge clk);
  endtask

  // result side: random ready with bursts, plus one long hold-off on request
  initial begin : result_sink
    int unsigned run;
    int unsigned mode;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        run  = $urandom_range(1, 40);
        mode = $urandom_range(0, 9);
        repeat (run) begin
          if (mode < 3)      out_ready <= 1'b1;
          else if (mode < 8) out_ready <= ($urandom_range(0, 99) < 70);
          else if (mode < 9) out_ready <= ($urandom_range(0, 99) < 25);
          else               out_ready <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  // stimulus and verdict
  initial begin : stimulus
    int unsigned       tick_pct;
    int unsigned       r;
    logic [TimeW-1:0]  len;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: idle tick, field extremes, zero length, overwrite of the running job
    send_cmd(CmdTick, '0, '0);
    send_cmd(CmdArrive, 4'd0, 24'd1);
    send_cmd(CmdArrive, 4'd15, 24'hFFFFFF);
    send_cmd(CmdTick, '0, '0);
    send_cmd(CmdTick, '0, '0);
    send_cmd(CmdArrive, 4'd3, 24'd0);
    send_cmd(CmdArrive, 4'd15, 24'd2);
    send_cmd(CmdTick, 4'hF, 24'hFFFFFF);
    send_cmd(CmdTick, '0, '0);
    send_cmd(CmdTick, '0, '0);
    send_cmd(CmdTick, '0, '0);
    send_cmd(CmdTick, '0, '0);
    send_cmd(CmdArrive, 4'd7, 24'd5);
    send_cmd(CmdArrive, 4'd8, 24'd2);
    send_cmd(CmdArrive, 4'd9, 24'h800000);
    send_cmd(CmdArrive, 4'd10, 24'h555555);
    send_cmd(CmdArrive, 4'd10, 24'hAAAAAA);
    send_cmd(CmdTick, '0, '0);
    send_cmd(CmdTick, '0, '0);
    send_cmd(CmdTick, '0, '0);

    // random phases, each under its own policy and quantum
    for (int ph = 0; ph < 8; ph++) begin
      drain(4);
      cfg_write(CfgPolicy, QuantW'(phase_pol[ph]));
      cfg_write(CfgQuantum, phase_quant[ph]);
      cfg_valid <= 1'b0;
      tick_pct = $urandom_range(50, 85);
      for (int n = 0; n < 80; n++) begin
        if (ph == 1 && n == 10) hold_req <= 1'b1;
        if (ph == 4 && n == 40) drain(0);
        // mostly short jobs so slots retire, a few long ones to exercise the upper bits
        r = $urandom_range(0, 99);
        if (r < 70)      len = TimeW'($urandom_range(1, 6));
        else if (r < 88) len = TimeW'($urandom_range(7, 40));
        else if (r < 95) len = TimeW'($urandom_range(41, 4095));
        else if (r < 98) len = TimeW'($urandom_range(0, 24'hFFFFFF));
        else             len = r[0] ? 24'hFFFFFF : 24'd0;
        send_cmd(($urandom_range(0, 99) < tick_pct) ? CmdTick : CmdArrive,
                 SlotW'($urandom_range(0, Slots - 1)), len);
      end
    end

    drain(40);
    if (fail_count == 0) begin
      $display("** cpu_process_scheduler: PASSED **");
    end else begin
      $display("** cpu_process_scheduler: FAILED **");
    end
    $finish;
  end

  // watchdog
  initial begin : watchdog
    #5_000_000;
    $display("** cpu_process_scheduler: FAILED **");
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/cps_pkg.sv
rtl/cps_job_table.sv
rtl/cps_scan_unit.sv
rtl/cpu_process_scheduler.sv
tb/sv/cps_checker.sv
tb/sv/tb_cpu_process_scheduler.sv
